// ===== hw/rtl/oga_pkg.sv =====
// Package for the oriented Gaussian weight block: payload types, register map,
// fixed-point constants and the sine and exponent tables.
// Depends on nothing; used by oriented_gaussian_weight_top.
`default_nettype none

package oga_pkg;

    typedef struct packed {
        logic [7:0] pre_feature;
        logic [7:0] post_feature;
        logic [9:0] pre_x;
        logic [9:0] pre_y;
        logic [9:0] post_x;
        logic [9:0] post_y;
    } in_t;

    typedef struct packed {
        logic [15:0] weight;
        logic        inside_res;
    } out_t;

    localparam int NUM_ORIENT_DEF = 8;
    localparam int ANGLE_STEP_DEF = 5760;
    localparam int GRID_X_DEF     = 64;
    localparam int GRID_Y_DEF     = 64;
    localparam int PBC_ENABLE_DEF = 1;

    localparam logic [2:0] REG_PRE_FEATURES     = 3'd0;
    localparam logic [2:0] REG_POST_FEATURES    = 3'd1;
    localparam logic [2:0] REG_DTH_MAX          = 3'd2;
    localparam logic [2:0] REG_INV_SIGMA_THETA2 = 3'd3;
    localparam logic [2:0] REG_SIGNED_OFFSET    = 3'd4;
    localparam logic [2:0] REG_ASPECT_SQ        = 3'd5;
    localparam logic [2:0] REG_R2               = 3'd6;
    localparam logic [2:0] REG_INV_SIGMA2       = 3'd7;

    localparam int PRE_FEATURES_RST  = 8;
    localparam int POST_FEATURES_RST = 8;
    localparam logic [14:0] DTH_MAX_RST          = 15'd23040;
    localparam logic [23:0] INV_SIGMA_THETA2_RST = 24'd4096;
    localparam logic [10:0] SIGNED_OFFSET_RST    = 11'd0;
    localparam logic [11:0] ASPECT_SQ_RST        = 12'd256;
    localparam logic [23:0] R2_RST               = 24'd16384;
    localparam logic [23:0] INV_SIGMA2_RST       = 24'd4096;

    // angles in Q9.8 degrees
    localparam logic [16:0] DEG90  = 17'd23040;
    localparam logic [16:0] DEG180 = 17'd46080;
    localparam logic [16:0] DEG270 = 17'd69120;
    localparam logic [16:0] DEG360 = 17'd92160;
    localparam int          DEG360_I = 92160;
    localparam int          ROM_STEP = 768;
    localparam int          ROM_LAST = 30;

    localparam logic [19:0] EXP_CAP = 20'd786432;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;
    localparam logic [15:0] RECIP3  = 16'd43691;

    // quarter-wave sine, 3 degree steps, Q1.14; past the end holds the peak
    function automatic logic [14:0] sin_rom(input logic [4:0] i);
        logic [14:0] v;
        case (i)
            5'd0:  v = 15'd0;
            5'd1:  v = 15'd857;
            5'd2:  v = 15'd1713;
            5'd3:  v = 15'd2563;
            5'd4:  v = 15'd3406;
            5'd5:  v = 15'd4240;
            5'd6:  v = 15'd5063;
            5'd7:  v = 15'd5872;
            5'd8:  v = 15'd6664;
            5'd9:  v = 15'd7438;
            5'd10: v = 15'd8192;
            5'd11: v = 15'd8923;
            5'd12: v = 15'd9630;
            5'd13: v = 15'd10311;
            5'd14: v = 15'd10963;
            5'd15: v = 15'd11585;
            5'd16: v = 15'd12176;
            5'd17: v = 15'd12733;
            5'd18: v = 15'd13255;
            5'd19: v = 15'd13741;
            5'd20: v = 15'd14189;
            5'd21: v = 15'd14598;
            5'd22: v = 15'd14968;
            5'd23: v = 15'd15296;
            5'd24: v = 15'd15582;
            5'd25: v = 15'd15826;
            5'd26: v = 15'd16026;
            5'd27: v = 15'd16182;
            5'd28: v = 15'd16294;
            5'd29: v = 15'd16362;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // exp(-n) in Q1.24 for whole n
    function automatic logic [24:0] exp_whole(input logic [3:0] n);
        logic [24:0] v;
        case (n)
            4'd0:  v = 25'd16777216;
            4'd1:  v = 25'd6171993;
            4'd2:  v = 25'd2270549;
            4'd3:  v = 25'd835288;
            4'd4:  v = 25'd307285;
            4'd5:  v = 25'd113044;
            4'd6:  v = 25'd41587;
            4'd7:  v = 25'd15299;
            4'd8:  v = 25'd5628;
            4'd9:  v = 25'd2070;
            4'd10: v = 25'd762;
            4'd11: v = 25'd280;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

    // exp(-n/16) in Q1.24
    function automatic logic [24:0] exp_sixteenth(input logic [3:0] n);
        logic [24:0] v;
        case (n)
            4'd0:  v = 25'd16777216;
            4'd1:  v = 25'd15760736;
            4'd2:  v = 25'd14805841;
            4'd3:  v = 25'd13908801;
            4'd4:  v = 25'd13066109;
            4'd5:  v = 25'd12274473;
            4'd6:  v = 25'd11530801;
            4'd7:  v = 25'd10832185;
            4'd8:  v = 25'd10175896;
            4'd9:  v = 25'd9559370;
            4'd10: v = 25'd8980197;
            4'd11: v = 25'd8436114;
            4'd12: v = 25'd7924996;
            4'd13: v = 25'd7444844;
            4'd14: v = 25'd6993784;
            default: v = 25'd6570611;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/oriented_gaussian_weight_top.sv =====
// Oriented anisotropic Gaussian weight, 23-stage pipeline with APB registers.
// Depends on oga_pkg (types, register map, sine and exponent tables).
//
// channel   signals                       handshake
// command   start, busy, item             taken when start && !busy
// result    done, result                  one-cycle strobe, no back-pressure
// config    psel..pwdata, prdata, pready  APB write in access phase
//
// One item enters per cycle; busy never rises.
// A result passes stage registers 0 to 21 and the output register; the depth comes from
// the quotient stages, the two trig lanes and the chained exponent multiplies.
// Reset clears the valid bits and loads the register defaults.
// The divisors follow a register write in the next cycle.
`default_nettype none

module oriented_gaussian_weight_top #(
    parameter int NUM_ORIENT = oga_pkg::NUM_ORIENT_DEF,
    parameter int ANGLE_STEP = oga_pkg::ANGLE_STEP_DEF,
    parameter int GRID_X     = oga_pkg::GRID_X_DEF,
    parameter int GRID_Y     = oga_pkg::GRID_Y_DEF,
    parameter int PBC_ENABLE = oga_pkg::PBC_ENABLE_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire oga_pkg::in_t item,
    output logic              done,
    output oga_pkg::out_t     result,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LAST = 21;
    localparam logic [8:0]  NUM_ORIENT_W = 9'(NUM_ORIENT);
    localparam logic [23:0] STEP_W = 24'(ANGLE_STEP);
    localparam logic [15:0] HALF_X = 16'((GRID_X / 2) * 16);
    localparam logic [15:0] FULL_X = 16'(GRID_X * 16);
    localparam logic [15:0] HALF_Y = 16'((GRID_Y / 2) * 16);
    localparam logic [15:0] FULL_Y = 16'(GRID_Y * 16);
    localparam int NKP_I = oga_pkg::PRE_FEATURES_RST / NUM_ORIENT;
    localparam int NKQ_I = oga_pkg::POST_FEATURES_RST / NUM_ORIENT;
    localparam logic [8:0] NKP_RST = (NKP_I == 0) ? 9'd1 : 9'(NKP_I);
    localparam logic [8:0] NKQ_RST = (NKQ_I == 0) ? 9'd1 : 9'(NKQ_I);
    // reciprocal of NUM_ORIENT, exact floor for any 9-bit count
    localparam logic [18:0] NK_RECIP = 19'((2**18 + NUM_ORIENT - 1) / NUM_ORIENT);

    // ---------------- functions ----------------
    // two quotient bits per call: {remainder, quotient bits}
    function automatic logic [10:0] div2(input logic [8:0] rem_in, input logic [1:0] bits,
                                         input logic [8:0] den);
        logic [9:0] r;
        logic [8:0] rr;
        logic [1:0] q;
        rr = rem_in;
        q = '0;
        for (int j = 1; j >= 0; j--) begin
            r = {rr, bits[j]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[j] = 1'b1;
            end
            rr = r[8:0];
        end
        return {rr, q};
    endfunction

    function automatic logic signed [15:0] wrap_d(input logic signed [10:0] d,
                                                  input logic [15:0] half,
                                                  input logic [15:0] full);
        logic signed [15:0] de;
        logic signed [15:0] ad;
        logic signed [15:0] rest;
        de = 16'(d);
        ad = (de < 0) ? -de : de;
        rest = signed'(full) - ad;
        if (PBC_ENABLE != 0 && ad > signed'(half))
            return (de > 0) ? -rest : rest;
        return de;
    endfunction

    // quadrant fold: {negate, angle within first quadrant}
    function automatic logic [15:0] trig_prep(input logic [16:0] r);
        logic [16:0] a;
        logic [1:0]  q;
        logic [16:0] arg;
        if (r >= oga_pkg::DEG270) begin
            q = 2'd3;
            a = r - oga_pkg::DEG270;
        end else if (r >= oga_pkg::DEG180) begin
            q = 2'd2;
            a = r - oga_pkg::DEG180;
        end else if (r >= oga_pkg::DEG90) begin
            q = 2'd1;
            a = r - oga_pkg::DEG90;
        end else begin
            q = 2'd0;
            a = r;
        end
        arg = q[0] ? oga_pkg::DEG90 - a : a;
        return {q[1], arg[14:0]};
    endfunction

    // table step of 768 taken as (arg >> 8) / 3
    function automatic logic [4:0] rom_index(input logic [14:0] arg);
        logic [15:0] prod;
        prod = 16'(arg[14:8]) * 16'd171;
        return prod[13:9];
    endfunction

    // ---------------- configuration ----------------
    logic [8:0]         pre_features_reg, post_features_reg;
    logic [14:0]        dth_max_reg;
    logic [23:0]        inv_sigma_theta2_reg, r2_reg, inv_sigma2_reg;
    logic signed [10:0] signed_offset_reg;
    logic [11:0]        aspect_sq_reg;
    logic [8:0]         nk_p_reg, nk_q_reg, nk_p_next, nk_q_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_features_reg     <= 9'(oga_pkg::PRE_FEATURES_RST);
            post_features_reg    <= 9'(oga_pkg::POST_FEATURES_RST);
            dth_max_reg          <= oga_pkg::DTH_MAX_RST;
            inv_sigma_theta2_reg <= oga_pkg::INV_SIGMA_THETA2_RST;
            signed_offset_reg    <= signed'(oga_pkg::SIGNED_OFFSET_RST);
            aspect_sq_reg        <= oga_pkg::ASPECT_SQ_RST;
            r2_reg               <= oga_pkg::R2_RST;
            inv_sigma2_reg       <= oga_pkg::INV_SIGMA2_RST;
            nk_p_reg             <= NKP_RST;
            nk_q_reg             <= NKQ_RST;
        end
        else
        begin
            nk_p_reg <= nk_p_next;
            nk_q_reg <= nk_q_next;
            if (wr_en)
            begin
                case (paddr[4:2])
                    oga_pkg::REG_PRE_FEATURES:     pre_features_reg     <= pwdata[8:0];
                    oga_pkg::REG_POST_FEATURES:    post_features_reg    <= pwdata[8:0];
                    oga_pkg::REG_DTH_MAX:          dth_max_reg          <= pwdata[14:0];
                    oga_pkg::REG_INV_SIGMA_THETA2: inv_sigma_theta2_reg <= pwdata[23:0];
                    oga_pkg::REG_SIGNED_OFFSET:    signed_offset_reg    <= signed'(pwdata[10:0]);
                    oga_pkg::REG_ASPECT_SQ:        aspect_sq_reg        <= pwdata[11:0];
                    oga_pkg::REG_R2:               r2_reg               <= pwdata[23:0];
                    oga_pkg::REG_INV_SIGMA2:       inv_sigma2_reg       <= pwdata[23:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        nk_p_next = 9'((28'(pre_features_reg) * 28'(NK_RECIP)) >> 18);
        nk_q_next = 9'((28'(post_features_reg) * 28'(NK_RECIP)) >> 18);
        if (nk_p_next == 9'd0)
            nk_p_next = 9'd1;
        if (nk_q_next == 9'd0)
            nk_q_next = 9'd1;
    end

    always_comb
    begin
        case (paddr[4:2])
            oga_pkg::REG_PRE_FEATURES:     prdata = {23'b0, pre_features_reg};
            oga_pkg::REG_POST_FEATURES:    prdata = {23'b0, post_features_reg};
            oga_pkg::REG_DTH_MAX:          prdata = {17'b0, dth_max_reg};
            oga_pkg::REG_INV_SIGMA_THETA2: prdata = {8'b0, inv_sigma_theta2_reg};
            oga_pkg::REG_SIGNED_OFFSET:    prdata = {21'b0, signed_offset_reg};
            oga_pkg::REG_ASPECT_SQ:        prdata = {20'b0, aspect_sq_reg};
            oga_pkg::REG_R2:               prdata = {8'b0, r2_reg};
            oga_pkg::REG_INV_SIGMA2:       prdata = {8'b0, inv_sigma2_reg};
            default:                       prdata = '0;
        endcase
    end

    // ---------------- angle table ----------------
    logic [16:0] ang_mod [0:255];
    for (genvar g = 0; g < 256; g++)
    begin : g_ang
        assign ang_mod[g] = 17'((g * ANGLE_STEP) % oga_pkg::DEG360_I);
    end

    // ---------------- pipeline registers ----------------
    logic               vld_reg [0:LAST];
    logic signed [15:0] dx_reg [0:9], dy_reg [0:9];
    logic [7:0]         dd_p_reg [0:3], dd_q_reg [0:3];
    logic [8:0]         rem_p_reg [1:3], rem_q_reg [1:3];
    logic [7:0]         q_p_reg [1:4], q_q_reg [1:4];
    logic [10:0]        dv_p [1:4], dv_q [1:4];
    logic [23:0]        dtr_reg, dtr_next;
    logic [16:0]        tm_reg, tm_next;
    logic [23:0]        adt_reg, adt_next;
    logic               ang_ok_reg [6:16];
    logic               ang_ok_next;
    logic [14:0]        sarg_reg, carg_reg;
    logic               sneg_reg [6:8], cneg_reg [6:8];
    logic [15:0]        sprep, cprep;
    logic [47:0]        sq_reg;
    logic [14:0]        sbase_reg [7:8], cbase_reg [7:8];
    logic [9:0]         sdiff_reg, cdiff_reg, sf_reg, cf_reg;
    logic [4:0]         si, ci;
    logic [47:0]        ahi_reg;
    logic [23:0]        alo_reg;
    logic [19:0]        sp_reg, cp_reg;
    logic [19:0]        xa_reg [9:16];
    logic [19:0]        xa_next;
    logic [48:0]        at_sum;
    logic signed [15:0] sin_reg, cos_reg, sin_next, cos_next;
    logic [14:0]        sv, cv;
    logic signed [31:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [31:0] dxp_reg, dyp_reg, dxp_next, dyp_next;
    logic [18:0]        ax_reg, ay_reg, ax_next, ay_next;
    logic [29:0]        ax2_reg [13:14];
    logic [29:0]        ay2_reg;
    logic [33:0]        aya_reg;
    logic [34:0]        d2_reg;
    logic               rad_ok_reg;
    logic [50:0]        shi_reg;
    logic [23:0]        slo_reg;
    logic [51:0]        st_sum;
    logic [19:0]        xs;
    logic [20:0]        x_reg, x_next;
    logic               ok_reg [17:21];
    logic               zero_reg [18:21];
    logic [19:0]        g_reg [18:19];
    logic [39:0]        gg_reg;
    logic [49:0]        w_reg;
    logic [14:0]        t1_reg;
    logic [35:0]        m_reg;
    logic [24:0]        vexp_reg [19:20];
    logic [24:0]        p_reg, p_next;
    logic [27:0]        c6_prod;
    logic [25:0]        vp_reg;
    logic [26:0]        vr;
    logic [18:0]        rr;
    oga_pkg::out_t      result_reg, result_next;
    logic               done_reg;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
                vld_reg[k] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int k = 1; k <= LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
            done_reg <= vld_reg[LAST];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- datapath ----------------
    always_comb
    begin
        dv_p[1] = div2(9'd0, dd_p_reg[0][7:6], nk_p_reg);
        dv_q[1] = div2(9'd0, dd_q_reg[0][7:6], nk_q_reg);
        for (int k = 2; k <= 4; k++)
        begin
            dv_p[k] = div2(rem_p_reg[k-1], dd_p_reg[k-1][7:6], nk_p_reg);
            dv_q[k] = div2(rem_q_reg[k-1], dd_q_reg[k-1][7:6], nk_q_reg);
        end
    end

    // select the orientation case and the raw angle difference
    always_comb
    begin
        logic [23:0] a;
        logic [23:0] b;
        logic        pre_many;
        logic        post_many;
        a = 24'(q_p_reg[4]) * STEP_W;
        b = 24'(q_q_reg[4]) * STEP_W;
        pre_many  = (pre_features_reg >= NUM_ORIENT_W);
        post_many = (post_features_reg >= NUM_ORIENT_W);
        if (pre_many && post_many)
        begin
            dtr_next = (a > b) ? a - b : b - a;
            tm_next  = ang_mod[q_p_reg[4]];
        end
        else if (pre_many && post_features_reg == 9'd1)
        begin
            dtr_next = a;
            tm_next  = ang_mod[q_p_reg[4]];
        end
        else if (pre_features_reg == 9'd1 && post_many)
        begin
            dtr_next = b;
            tm_next  = ang_mod[q_q_reg[4]];
        end
        else
        begin
            dtr_next = '0;
            tm_next  = '0;
        end
    end

    // fold at 90 degrees, angle limit, trig quadrant
    always_comb
    begin
        logic signed [24:0] dts;
        logic [16:0]        rc;
        dts = (dtr_reg > 24'(oga_pkg::DEG90)) ?
              25'(oga_pkg::DEG180) - signed'({1'b0, dtr_reg}) : signed'({1'b0, dtr_reg});
        ang_ok_next = !(dts > signed'({10'b0, dth_max_reg}));
        adt_next = (dts < 0) ? 24'(-dts) : 24'(dts);
        rc = tm_reg + oga_pkg::DEG90;
        if (rc >= oga_pkg::DEG360)
            rc = rc - oga_pkg::DEG360;
        sprep = trig_prep(tm_reg);
        cprep = trig_prep(rc);
    end

    assign si = rom_index(sarg_reg);
    assign ci = rom_index(carg_reg);

    always_comb
    begin
        at_sum  = {1'b0, ahi_reg} + 49'(alo_reg);
        xa_next = (at_sum > 49'(oga_pkg::EXP_CAP)) ? oga_pkg::EXP_CAP : at_sum[19:0];
        sv = sbase_reg[8] + 15'((29'(sp_reg[19:8]) * 29'(oga_pkg::RECIP3)) >> 17);
        cv = cbase_reg[8] + 15'((29'(cp_reg[19:8]) * 29'(oga_pkg::RECIP3)) >> 17);
        sin_next = sneg_reg[8] ? -signed'({1'b0, sv}) : signed'({1'b0, sv});
        cos_next = cneg_reg[8] ? -signed'({1'b0, cv}) : signed'({1'b0, cv});
    end

    always_comb
    begin
        logic [31:0] amx;
        logic [31:0] amy;
        dxp_next = pxc_reg + pys_reg;
        dyp_next = pyc_reg - pxs_reg - (32'(signed_offset_reg) <<< 14);
        amx = (dxp_reg < 0) ? 32'(-dxp_reg) : 32'(dxp_reg);
        amy = (dyp_reg < 0) ? 32'(-dyp_reg) : 32'(dyp_reg);
        ax_next = 19'((amx + 32'd512) >> 10);
        ay_next = 19'((amy + 32'd512) >> 10);
    end

    always_comb
    begin
        st_sum = {1'b0, shi_reg} + 52'(slo_reg);
        xs     = (st_sum > 52'(oga_pkg::EXP_CAP)) ? oga_pkg::EXP_CAP : st_sum[19:0];
        x_next = 21'(xa_reg[16]) + 21'(xs);
    end

    always_comb
    begin
        logic [11:0] mm;
        mm      = 12'(m_reg[35:25]);
        c6_prod = 28'(mm) * 28'(oga_pkg::RECIP3);
        p_next  = oga_pkg::ONE_Q24 - 25'(g_reg[19]) + 25'(t1_reg) - 25'(c6_prod[27:17]);
    end

    always_comb
    begin
        vr = 27'(vp_reg) + 27'd128;
        rr = vr[26:8];
        result_next.inside_res = ok_reg[21];
        if (!ok_reg[21] || zero_reg[21])
            result_next.weight = '0;
        else if (rr > 19'd65535)
            result_next.weight = 16'hFFFF;
        else
            result_next.weight = rr[15:0];
    end

    always_ff @(posedge clk)
    begin
        // stage 0: differences with periodic wrap, dividends
        dx_reg[0] <= wrap_d(signed'({1'b0, item.pre_x}) - signed'({1'b0, item.post_x}),
                            HALF_X, FULL_X);
        dy_reg[0] <= wrap_d(signed'({1'b0, item.pre_y}) - signed'({1'b0, item.post_y}),
                            HALF_Y, FULL_Y);
        dd_p_reg[0] <= item.pre_feature;
        dd_q_reg[0] <= item.post_feature;
        for (int k = 1; k <= 9; k++)
        begin
            dx_reg[k] <= dx_reg[k-1];
            dy_reg[k] <= dy_reg[k-1];
        end

        // stages 1-4: orientation index, two quotient bits per stage
        for (int k = 1; k <= 3; k++)
        begin
            dd_p_reg[k]  <= {dd_p_reg[k-1][5:0], 2'b00};
            dd_q_reg[k]  <= {dd_q_reg[k-1][5:0], 2'b00};
            rem_p_reg[k] <= dv_p[k][10:2];
            rem_q_reg[k] <= dv_q[k][10:2];
        end
        q_p_reg[1] <= {6'b0, dv_p[1][1:0]};
        q_q_reg[1] <= {6'b0, dv_q[1][1:0]};
        for (int k = 2; k <= 4; k++)
        begin
            q_p_reg[k] <= {q_p_reg[k-1][5:0], dv_p[k][1:0]};
            q_q_reg[k] <= {q_q_reg[k-1][5:0], dv_q[k][1:0]};
        end

        // stage 5
        dtr_reg <= dtr_next;
        tm_reg  <= tm_next;

        // stage 6
        adt_reg       <= adt_next;
        ang_ok_reg[6] <= ang_ok_next;
        for (int k = 7; k <= 16; k++)
            ang_ok_reg[k] <= ang_ok_reg[k-1];
        sarg_reg    <= sprep[14:0];
        carg_reg    <= cprep[14:0];
        sneg_reg[6] <= sprep[15];
        cneg_reg[6] <= cprep[15];
        for (int k = 7; k <= 8; k++)
        begin
            sneg_reg[k] <= sneg_reg[k-1];
            cneg_reg[k] <= cneg_reg[k-1];
        end

        // stage 7: square angle, sine table lookup
        sq_reg       <= 48'(adt_reg) * 48'(adt_reg);
        sbase_reg[7] <= oga_pkg::sin_rom(si);
        cbase_reg[7] <= oga_pkg::sin_rom(ci);
        sdiff_reg    <= 10'(oga_pkg::sin_rom(si + 5'd1) - oga_pkg::sin_rom(si));
        cdiff_reg    <= 10'(oga_pkg::sin_rom(ci + 5'd1) - oga_pkg::sin_rom(ci));
        sf_reg       <= 10'(sarg_reg - {1'b0, si, 9'b0} - {2'b0, si, 8'b0});
        cf_reg       <= 10'(carg_reg - {1'b0, ci, 9'b0} - {2'b0, ci, 8'b0});
        sbase_reg[8] <= sbase_reg[7];
        cbase_reg[8] <= cbase_reg[7];

        // stage 8: angular products, interpolation
        ahi_reg <= 48'(sq_reg[47:24]) * 48'(inv_sigma_theta2_reg);
        alo_reg <= 24'((48'(sq_reg[23:0]) * 48'(inv_sigma_theta2_reg)) >> 24);
        sp_reg  <= 20'(20'(sdiff_reg) * 20'(sf_reg)) + 20'd384;
        cp_reg  <= 20'(20'(cdiff_reg) * 20'(cf_reg)) + 20'd384;

        // stage 9
        xa_reg[9] <= xa_next;
        for (int k = 10; k <= 16; k++)
            xa_reg[k] <= xa_reg[k-1];
        sin_reg <= sin_next;
        cos_reg <= cos_next;

        // stage 10: rotation products
        pxc_reg <= 32'(dx_reg[9]) * 32'(cos_reg);
        pys_reg <= 32'(dy_reg[9]) * 32'(sin_reg);
        pyc_reg <= 32'(dy_reg[9]) * 32'(cos_reg);
        pxs_reg <= 32'(dx_reg[9]) * 32'(sin_reg);

        // stages 11-15: distance
        dxp_reg    <= dxp_next;
        dyp_reg    <= dyp_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        ax2_reg[13] <= 30'((38'(ax_reg) * 38'(ax_reg)) >> 8);
        ay2_reg     <= 30'((38'(ay_reg) * 38'(ay_reg)) >> 8);
        ax2_reg[14] <= ax2_reg[13];
        aya_reg     <= 34'((42'(ay2_reg) * 42'(aspect_sq_reg)) >> 8);
        d2_reg      <= 35'(ax2_reg[14]) + 35'(aya_reg);

        // stage 16: radius limit, spatial products
        rad_ok_reg <= (d2_reg <= 35'(r2_reg));
        shi_reg    <= 51'(d2_reg[34:8]) * 51'(inv_sigma2_reg);
        slo_reg    <= 24'((32'(d2_reg[7:0]) * 32'(inv_sigma2_reg)) >> 8);

        // stage 17
        x_reg      <= x_next;
        ok_reg[17] <= ang_ok_reg[16] && rad_ok_reg;
        for (int k = 18; k <= 21; k++)
            ok_reg[k] <= ok_reg[k-1];

        // stages 18-21: exponent
        zero_reg[18] <= (x_reg >= 21'(oga_pkg::EXP_CAP));
        for (int k = 19; k <= 21; k++)
            zero_reg[k] <= zero_reg[k-1];
        g_reg[18] <= {x_reg[11:0], 8'b0};
        g_reg[19] <= g_reg[18];
        gg_reg    <= 40'({x_reg[11:0], 8'b0}) * 40'({x_reg[11:0], 8'b0});
        w_reg     <= 50'(oga_pkg::exp_whole(x_reg[19:16]))
                     * 50'(oga_pkg::exp_sixteenth(x_reg[15:12]));
        t1_reg       <= gg_reg[39:25];
        m_reg        <= 36'(gg_reg[39:24]) * 36'(g_reg[18]);
        vexp_reg[19] <= w_reg[48:24];
        vexp_reg[20] <= vexp_reg[19];
        p_reg        <= p_next;
        vp_reg       <= 26'((50'(vexp_reg[20]) * 50'(p_reg)) >> 24);

        // output
        result_reg <= result_next;
    end

    // ---------------- assertions ----------------
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.inside_res |-> result.weight == 16'd0)
        else $error("rejected transaction carries a nonzero weight");

    a_angle_reject: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[16] && !ang_ok_reg[16] |=> !ok_reg[17])
        else $error("angle rejection lost before exponent stage");

    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        nk_p_reg != 9'd0 && nk_q_reg != 9'd0)
        else $error("orientation divisor is zero");

endmodule

`default_nettype wire
